FILE: rtl/netconf_message_deframer_top_assert.svh
// assertion macros for the checker file nmd_port_chk
`ifndef NETCONF_MESSAGE_DEFRAMER_TOP_ASSERT_SVH
`define NETCONF_MESSAGE_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define NMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define NMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nmd_pkg.sv
`default_nettype none

package nmd_pkg;

    // default sizes of the chunk size parser
    localparam int DEF_SIZE_BITS       = 32;
    localparam int DEF_MAX_SIZE_DIGITS = 10;

    // fixed field widths
    localparam int COUNT_W = 4;    // message counter, limit, digit counter
    localparam int MATCH_W = 3;    // bytes of the end marker matched so far
    localparam int RES_W   = 3;    // results of one input byte, up to six
    localparam int TDATA_W = 16;
    localparam int TUSER_W = 2;

    // configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int CFG_IDX_LSB = 2;
    localparam int CFG_IDX_W   = PADDR_W - CFG_IDX_LSB;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT = '0;
    localparam logic [COUNT_W-1:0]   LIMIT_RESET       = 4'd3;

    // characters of the framing grammar
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    // last position of the end marker ]]>]]>
    localparam logic [MATCH_W-1:0] MARK_LAST = 3'd5;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_START_LF   = 4'd1,
        PH_EOM        = 4'd2,
        PH_HDR_LF     = 4'd3,
        PH_HDR_HASH   = 4'd4,
        PH_SIZE_FIRST = 4'd5,
        PH_SIZE       = 4'd6,
        PH_DATA       = 4'd7,
        PH_END_LF     = 4'd8,
        PH_DISCARD    = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HDR    = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_OVERSIZE   = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_LIMIT      = 3'd5
    } status_t;

    // everything one input byte produces, in compact form:
    // payload bytes are an optional LF, then the first n of
    // (marker bytes 0..m-1, received byte); an optional control result ends the run
    typedef struct packed {
        logic                lf_pre;
        logic [MATCH_W-1:0]  m;
        logic [7:0]          b;
        logic [RES_W-1:0]    n_bytes;
        logic                ctl;
        logic                ctl_done;
        status_t             ctl_status;
        logic                trunc;
        logic [COUNT_W-1:0]  index;
        logic                chunked;
    } bundle_t;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                payload_valid;
        logic [COUNT_W-1:0]  message_index;
        logic                message_done;
        logic                chunked_mode;
        status_t             status;
        logic                run_last;
    } result_t;

    // byte at a position of the end marker ]]>]]>
    function automatic logic [7:0] mark_byte(input logic [MATCH_W-1:0] idx);
        return (idx == 3'd2 || idx == MARK_LAST) ? CH_GT : CH_RBRACKET;
    endfunction

    // marker bytes still matched after a mismatch; only "]]" can survive,
    // after "]]" or "]]>]]" followed by another ']'
    function automatic logic [MATCH_W-1:0] eom_keep(input logic [MATCH_W-1:0] m,
                                                    input logic [7:0] b);
        return (b == CH_RBRACKET && (m == 3'd2 || m == MARK_LAST)) ? 3'd2 : 3'd0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/nmd_cfg.sv
`default_nettype none

module nmd_cfg
    import nmd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    output logic      [COUNT_W-1:0]  message_limit
);

    logic [COUNT_W-1:0]   limit_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // register decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:CFG_IDX_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en && reg_idx == REG_MESSAGE_LIMIT)
        begin
            limit_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // register read
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_MESSAGE_LIMIT)
        begin
            prdata = {{(PDATA_W-COUNT_W){1'b0}}, limit_reg};
        end
    end

    assign message_limit = limit_reg;

endmodule

`default_nettype wire

FILE: rtl/nmd_parse.sv
`default_nettype none

module nmd_parse
    import nmd_pkg::*;
#(
    parameter int SIZE_BITS       = DEF_SIZE_BITS,
    parameter int MAX_SIZE_DIGITS = DEF_MAX_SIZE_DIGITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          in_byte,
    input  wire logic                buffer_end,
    input  wire logic [COUNT_W-1:0]  message_limit,
    output bundle_t                  bundle
);

    localparam logic [COUNT_W-1:0] MAX_DIGITS = COUNT_W'(MAX_SIZE_DIGITS);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // parser state
    phase_t                 phase_reg,   phase_next;
    logic                   framing_reg, framing_next;
    logic [MATCH_W-1:0]     matched_reg, matched_next;
    logic [SIZE_BITS-1:0]   acc_reg,     acc_next;
    logic [SIZE_BITS-1:0]   left_reg,    left_next;
    logic [COUNT_W-1:0]     digits_reg,  digits_next;
    logic [COUNT_W-1:0]     msgs_reg,    msgs_next;
    logic                   seen_reg,    seen_next;

    // step decode
    logic                   feed;
    logic                   pass;
    logic                   close;
    logic                   fail;
    status_t                fail_code;
    logic [MATCH_W-1:0]     m_in;
    logic                   match;
    logic [MATCH_W-1:0]     keep;
    logic                   lf_pre;
    logic [RES_W-1:0]       rel_n;
    logic [RES_W-1:0]       n_bytes;
    logic                   ctl;
    logic                   ctl_done;
    status_t                ctl_status;
    logic                   trunc;
    logic                   res_chunked;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [SIZE_BITS+3:0]   prod;
    logic                   over;
    logic [SIZE_BITS-1:0]   left_dec;

    // size arithmetic: acc * 10 + digit, overflow in the top bits
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = in_byte[3:0];
    assign prod     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {{SIZE_BITS{1'b0}}, digit};
    assign over     = |prod[SIZE_BITS+3:SIZE_BITS];
    assign left_dec = (left_reg != '0) ? left_reg - SIZE_BITS'(1) : left_reg;

    // end marker compare
    assign match = (in_byte == mark_byte(m_in));
    assign keep  = eom_keep(m_in, in_byte);

    // next state and results of one byte
    always_comb
    begin
        phase_next   = phase_reg;
        framing_next = framing_reg;
        matched_next = matched_reg;
        acc_next     = acc_reg;
        left_next    = left_reg;
        digits_next  = digits_reg;
        msgs_next    = msgs_reg;
        seen_next    = seen_reg;
        feed         = 1'b0;
        pass         = 1'b0;
        close        = 1'b0;
        fail         = 1'b0;
        fail_code    = ST_BAD_HDR;
        m_in         = '0;
        lf_pre       = 1'b0;
        rel_n        = '0;
        ctl          = 1'b0;
        ctl_done     = 1'b0;
        ctl_status   = ST_OK;
        trunc        = 1'b0;

        // grammar
        unique case (phase_reg)
            PH_START:
            begin
                framing_next = 1'b0;
                if (msgs_reg >= message_limit)
                begin
                    ctl        = 1'b1;
                    ctl_status = ST_LIMIT;
                end
                else if (in_byte == CH_LF)
                begin
                    phase_next = PH_START_LF;
                end
                else
                begin
                    feed = 1'b1;
                end
            end
            PH_START_LF:
            begin
                if (in_byte == CH_HASH)
                begin
                    framing_next = 1'b1;
                    seen_next    = 1'b0;
                    acc_next     = '0;
                    digits_next  = '0;
                    phase_next   = PH_SIZE_FIRST;
                end
                else
                begin
                    lf_pre = 1'b1;
                    feed   = 1'b1;
                end
            end
            PH_EOM:
            begin
                feed = 1'b1;
                m_in = (matched_reg > MARK_LAST) ? '0 : matched_reg;
            end
            PH_HDR_LF:
            begin
                if (in_byte == CH_LF)
                begin
                    phase_next = PH_HDR_HASH;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_HDR_HASH:
            begin
                if (in_byte == CH_HASH)
                begin
                    acc_next    = '0;
                    digits_next = '0;
                    phase_next  = PH_SIZE_FIRST;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_SIZE_FIRST:
            begin
                if (in_byte >= CH_ONE && in_byte <= CH_NINE)
                begin
                    acc_next    = SIZE_BITS'(digit);
                    digits_next = COUNT_W'(1);
                    phase_next  = PH_SIZE;
                end
                else if (in_byte == CH_ZERO)
                begin
                    fail      = 1'b1;
                    fail_code = ST_ZERO_SIZE;
                end
                else if (in_byte == CH_HASH && seen_reg)
                begin
                    phase_next = PH_END_LF;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_SIZE:
            begin
                if (is_digit)
                begin
                    if (digits_reg >= MAX_DIGITS || over)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_OVERSIZE;
                    end
                    else
                    begin
                        acc_next    = prod[SIZE_BITS-1:0];
                        digits_next = digits_reg + COUNT_W'(1);
                    end
                end
                else if (in_byte == CH_LF)
                begin
                    left_next  = acc_reg;
                    seen_next  = 1'b1;
                    phase_next = (acc_reg == '0) ? PH_HDR_LF : PH_DATA;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_DATA:
            begin
                pass      = 1'b1;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_HDR_LF;
                end
            end
            PH_END_LF:
            begin
                if (in_byte == CH_LF)
                begin
                    ctl      = 1'b1;
                    ctl_done = 1'b1;
                    close    = 1'b1;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_DISCARD:
            begin
                phase_next = PH_DISCARD;
            end
            default:
            begin
                phase_next = PH_DISCARD;
            end
        endcase

        // end marker matcher: withhold matched bytes, release on mismatch
        if (feed)
        begin
            phase_next = PH_EOM;
            if (match)
            begin
                if (m_in == MARK_LAST)
                begin
                    ctl      = 1'b1;
                    ctl_done = 1'b1;
                    close    = 1'b1;
                end
                else
                begin
                    matched_next = m_in + MATCH_W'(1);
                end
            end
            else
            begin
                matched_next = keep;
                rel_n        = RES_W'(m_in + MATCH_W'(1) - keep);
            end
        end

        // chunk data byte goes straight through
        if (pass)
        begin
            rel_n = RES_W'(1);
        end

        // bad framing closes the message with a status
        if (fail)
        begin
            ctl        = 1'b1;
            ctl_done   = 1'b1;
            ctl_status = fail_code;
            phase_next = PH_DISCARD;
        end

        // message complete
        if (close)
        begin
            msgs_next    = (msgs_reg == COUNT_MAX) ? msgs_reg : msgs_reg + COUNT_W'(1);
            phase_next   = PH_START;
            matched_next = '0;
        end

        // framing that the results of this byte report
        res_chunked = framing_next;

        // end of buffer: release withheld bytes, flag truncation, clear
        if (buffer_end)
        begin
            if (phase_next != PH_START && phase_next != PH_DISCARD)
            begin
                trunc = 1'b1;
                if (phase_next == PH_START_LF)
                begin
                    lf_pre = 1'b1;
                end
                else if (phase_next == PH_EOM)
                begin
                    rel_n = RES_W'(m_in + MATCH_W'(1));
                end
            end
            phase_next   = PH_START;
            framing_next = 1'b0;
            matched_next = '0;
            acc_next     = '0;
            left_next    = '0;
            digits_next  = '0;
            msgs_next    = '0;
            seen_next    = 1'b0;
        end

        n_bytes = rel_n + {{(RES_W-1){1'b0}}, lf_pre};
        if (trunc && n_bytes == '0)
        begin
            ctl        = 1'b1;
            ctl_done   = 1'b1;
            ctl_status = ST_TRUNCATED;
        end
    end

    // compact result description for the output stage
    always_comb
    begin
        bundle.lf_pre     = lf_pre;
        bundle.m          = m_in;
        bundle.b          = in_byte;
        bundle.n_bytes    = n_bytes;
        bundle.ctl        = ctl;
        bundle.ctl_done   = ctl_done;
        bundle.ctl_status = ctl_status;
        bundle.trunc      = trunc && (n_bytes != '0);
        bundle.index      = msgs_reg;
        bundle.chunked    = res_chunked;
    end

    // state registers, updated once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            framing_reg <= 1'b0;
            matched_reg <= '0;
            acc_reg     <= '0;
            left_reg    <= '0;
            digits_reg  <= '0;
            msgs_reg    <= '0;
            seen_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            framing_reg <= framing_next;
            matched_reg <= matched_next;
            acc_reg     <= acc_next;
            left_reg    <= left_next;
            digits_reg  <= digits_next;
            msgs_reg    <= msgs_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nmd_emit.sv
`default_nettype none

module nmd_emit
    import nmd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire bundle_t  bundle_in,
    output logic          ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       result
);

    bundle_t            bund_reg,   bund_next;
    logic [RES_W-1:0]   pos_reg,    pos_next;
    logic [RES_W-1:0]   left_reg,   left_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg,    out_next;

    logic               load_out;
    logic               have;
    logic               last_item;
    logic               take;
    logic [RES_W-1:0]   n_res_in;
    logic [MATCH_W-1:0] j;
    logic [7:0]         sbyte;
    result_t            item;

    // handshake: next byte taken when no run is pending or while the last result of the run moves out
    assign load_out  = !out_valid_reg || out_ready;
    assign have      = (left_reg != '0);
    assign last_item = (left_reg == RES_W'(1));
    assign ready     = !have || (last_item && load_out);
    assign take      = have && load_out;
    assign n_res_in  = bundle_in.n_bytes + {{(RES_W-1){1'b0}}, bundle_in.ctl};

    // result at the current position of the run
    always_comb
    begin
        j = pos_reg - {{(RES_W-1){1'b0}}, bund_reg.lf_pre};
        if (j < bund_reg.m)
        begin
            sbyte = mark_byte(j);
        end
        else
        begin
            sbyte = bund_reg.b;
        end

        item.message_index = bund_reg.index;
        item.chunked_mode  = bund_reg.chunked;
        item.run_last      = last_item;
        if (pos_reg < bund_reg.n_bytes)
        begin
            item.payload_byte  = (bund_reg.lf_pre && pos_reg == '0) ? CH_LF : sbyte;
            item.payload_valid = 1'b1;
            item.message_done  = bund_reg.trunc && (pos_reg == bund_reg.n_bytes - RES_W'(1));
            item.status        = item.message_done ? ST_TRUNCATED : ST_OK;
        end
        else
        begin
            item.payload_byte  = '0;
            item.payload_valid = 1'b0;
            item.message_done  = bund_reg.ctl_done;
            item.status        = bund_reg.ctl_status;
        end
    end

    // run bookkeeping and output register
    always_comb
    begin
        bund_next      = bund_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (load)
        begin
            bund_next = bundle_in;
            pos_next  = '0;
            left_next = n_res_in;
        end
        else if (take)
        begin
            pos_next  = pos_reg + RES_W'(1);
            left_next = left_reg - RES_W'(1);
        end

        if (load_out)
        begin
            out_valid_next = have;
            if (have)
            begin
                out_next = item;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bund_reg <= bund_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

FILE: rtl/netconf_message_deframer_top.sv
// channel  | direction | ports                           | transfer
// ---------+-----------+---------------------------------+--------------------------
// s        | in        | s_tvalid s_tready s_tdata s_tlast | one received byte
// m        | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | one result
// apb      | in        | psel penable pwrite paddr pwdata prdata pready | register access
//
// each accepted byte gives zero to six results, one result per cycle on m while m_tready is high
// a byte with a single result is taken every cycle while m is not stalled; a byte with
// several results holds s_tready low while the output register drains the run
// an s transfer reaches m through the run register and then the output register
// rst_n is asynchronous: parser state and m_tvalid clear, message_limit returns to 3
// a stall on m holds the output register; s is refused only when the run is still busy
`default_nettype none

module netconf_message_deframer_top
    import nmd_pkg::*;
#(
    parameter int SIZE_BITS       = DEF_SIZE_BITS,
    parameter int MAX_SIZE_DIGITS = DEF_MAX_SIZE_DIGITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,    // [7:0] in_byte
    input  wire logic                s_tlast,    // buffer_end

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,    // [7:0] payload_byte, [11:8] message_index,
                                                 // [12] message_done, [15:13] status
    output logic [TUSER_W-1:0]       m_tuser,    // [0] payload_valid, [1] chunked_mode
    output logic                     m_tlast,    // run_last

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    logic               s_accept;
    logic [COUNT_W-1:0] message_limit;
    bundle_t            bundle;
    result_t            result;

    assign s_accept = s_tvalid && s_tready;

    // configuration registers
    nmd_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .message_limit (message_limit)
    );

    // framing parser
    nmd_parse #(
        .SIZE_BITS       (SIZE_BITS),
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .in_byte       (s_tdata),
        .buffer_end    (s_tlast),
        .message_limit (message_limit),
        .bundle        (bundle)
    );

    // result run and output register
    nmd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s_accept),
        .bundle_in (bundle),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // output packing
    assign m_tdata = {result.status, result.message_done, result.message_index,
                      result.payload_byte};
    assign m_tuser = {result.chunked_mode, result.payload_valid};
    assign m_tlast = result.run_last;

endmodule

`default_nettype wire

FILE: rtl/nmd_port_chk.sv
`default_nettype none

`include "netconf_message_deframer_top_assert.svh"

module nmd_port_chk
    import nmd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [TDATA_W-1:0]  m_tdata,
    input  wire logic [TUSER_W-1:0]  m_tuser,
    input  wire logic                m_tlast
);

    // a stalled result holds
    `NMD_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // control results carry a zero byte
    `NMD_ASSERT_IMP(a_ctl_byte_zero, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'h00, "control result with nonzero byte")

    // a dropped byte at the limit stands alone and closes nothing
    `NMD_ASSERT_IMP(a_limit_shape, m_tvalid && m_tdata[15:13] == ST_LIMIT, !m_tuser[0] && !m_tdata[12] && !m_tuser[1] && m_tlast, "bad limit result")

    // truncation ends both the message and the run
    `NMD_ASSERT_IMP(a_trunc_last, m_tvalid && m_tdata[15:13] == ST_TRUNCATED, m_tdata[12] && m_tlast, "truncation not on last result")

endmodule

bind netconf_message_deframer_top nmd_port_chk u_port_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
